@@ hdl/sitdt_pkg.sv @@
// package for the signed integer to decimal text block
// holds field widths, character codes, payload structs and the state type; no dependencies
package sitdt_pkg;

    localparam int VALUE_WIDTH = 64;
    // decimal digits needed for any VALUE_WIDTH-bit magnitude
    localparam int DIGITS      = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W       = DIGITS * 4;
    localparam int CNT_W       = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int DCNT_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [6:0] CH_ZERO    = 7'd48;
    localparam logic [6:0] CH_MINUS   = 7'd45;
    localparam logic [6:0] CH_NEWLINE = 7'd10;

    typedef struct packed {
        logic signed [63:0] value;
        logic               mode;
    } t_in_item;

    typedef struct packed {
        logic [6:0] text_char;
        logic       last_char;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS,
        ST_NEWLINE
    } t_state;

endpackage

@@ hdl/signed_int_to_decimal_text.sv @@
// top level: signed integer to decimal ascii text, one character per strobe
// depends on sitdt_pkg for widths, character codes, payload structs and state type
//
// An item is taken when start is high and busy is low. The magnitude is
// converted by a bit-serial shift-and-add-3 pass, one bit per cycle. Then
// each leading zero is dropped in turn (no strobe), a further step finds the
// first kept digit, and each kept digit is printed. A '-' comes before the
// digits on negative values and a newline after them in mode 1. An item
// keeps the block busy up to its last character, and the next item can be
// taken in the cycle after the last character. Each character is on o_result
// for exactly one cycle with o_strobe high; the receiver cannot stall, so it
// must take every transfer. last_char marks the final one.
module signed_int_to_decimal_text
    import sitdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_state                   r_state, n_state;
    logic [VALUE_WIDTH-1:0]   r_mag, n_mag;
    logic [BCD_W-1:0]         r_bcd, n_bcd;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [DCNT_W-1:0]        r_dcnt, n_dcnt;
    logic                     r_neg, n_neg;
    logic                     r_nl, n_nl;

    logic [VALUE_WIDTH-1:0]   raw;
    logic [BCD_W-1:0]         bcd_adj;
    logic [3:0]               top_digit;
    logic                     accept;
    logic                     conv_done;
    logic                     last_pos;

    assign raw       = i_item.value[VALUE_WIDTH-1:0];
    assign accept    = start && (r_state == ST_IDLE);
    assign top_digit = r_bcd[BCD_W-1 -: 4];
    assign conv_done = (r_cnt == CNT_W'(VALUE_WIDTH - 1));
    assign last_pos  = (r_dcnt == DCNT_W'(DIGITS - 1));

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (conv_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((top_digit != 4'd0) || last_pos) begin
                    n_state = r_neg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (last_pos) begin
                    n_state = r_nl ? ST_NEWLINE : ST_IDLE;
                end
            end
            ST_NEWLINE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_dcnt = r_dcnt;
        n_neg  = r_neg;
        n_nl   = r_nl;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_neg  = raw[VALUE_WIDTH-1];
                    n_nl   = i_item.mode;
                    n_mag  = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
                    n_bcd  = '0;
                    n_cnt  = '0;
                    n_dcnt = '0;
                end
            end
            ST_CONVERT: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
            end
            ST_SKIP: begin
                // drop a leading zero, but always keep the units digit
                if ((top_digit == 4'd0) && !last_pos) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dcnt = r_dcnt + DCNT_W'(1);
                end
            end
            ST_DIGITS: begin
                n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                n_dcnt = r_dcnt + DCNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        busy               = (r_state != ST_IDLE);
        o_strobe           = 1'b0;
        o_result.text_char = CH_ZERO;
        o_result.last_char = 1'b0;
        case (r_state)
            ST_SIGN: begin
                o_strobe           = 1'b1;
                o_result.text_char = CH_MINUS;
            end
            ST_DIGITS: begin
                o_strobe           = 1'b1;
                o_result.text_char = CH_ZERO + {3'b000, top_digit};
                o_result.last_char = last_pos && !r_nl;
            end
            ST_NEWLINE: begin
                o_strobe           = 1'b1;
                o_result.text_char = CH_NEWLINE;
                o_result.last_char = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_dcnt <= n_dcnt;
        r_neg  <= n_neg;
        r_nl   <= n_nl;
    end

endmodule
